/* hw/rtl/pfa_pkg.sv */
// Shared constants, command and status types for the page frame allocator.
package pfa_pkg;

    // Fixed field widths
    localparam int OWNER_W  = 8;
    localparam int BYTES_W  = 16;
    localparam int STATUS_W = 2;
    localparam int ADDR_W   = 10;
    localparam int COUNT_W  = 5;

    // Operation codes
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_PAGES   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 2'd3;

    // Datapath step codes, one per scan kind
    localparam logic [2:0] STEP_NONE  = 3'd0;
    localparam logic [2:0] STEP_SLOT  = 3'd1;  // look for first inactive slot
    localparam logic [2:0] STEP_COUNT = 3'd2;  // sum free page capacity
    localparam logic [2:0] STEP_GRANT = 3'd3;  // mark free pages for owner
    localparam logic [2:0] STEP_FPAGE = 3'd4;  // release pages of owner
    localparam logic [2:0] STEP_FSLOT = 3'd5;  // deactivate slots of owner

    // Controller to datapath
    typedef struct packed {
        logic                load;      // capture input word, clear scan state
        logic                clr;       // restart index and capacity sum
        logic [2:0]          step;
        logic                claim;     // take the slot found earlier
        logic                res_load;  // load the output register
        logic [STATUS_W-1:0] res_code;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic slot_free;   // slot at index is inactive
        logic slot_last;   // index at last slot
        logic page_last;   // index at last page
        logic fits;        // nonzero request fits in free capacity
        logic need_more;   // granted capacity below request
        logic page_end;    // pipelined page scan done
        logic slot_end;    // pipelined slot scan done
        logic any_rel;     // at least one page released
        logic out_free;    // output register can take a word
    } t_sts;

endpackage

/* hw/rtl/page_frame_allocator_core.sv */
// Top level of the first-fit page frame allocator.
//
//  channel  direction  handshake                  payload
//  in       sink       i_in_valid / o_in_ready    i_func, i_owner_id, i_request_bytes
//  out      source     o_out_valid / i_out_ready  o_status, o_page_address, o_page_count
//
// One word is worked at a time; the scan index of the datapath sets the time.
// Allocate: slot scan up to the first inactive slot, free capacity sum over all pages, check,
// grant scan to the last granted page, slot claim, result; a full table ends after the slot scan.
// Free: page scan, slot scan. Reset (synchronous, active low) frees all pages and slots.
// A result waits in the output register while the next word is taken; a stalled
// output only holds the controller once its next result is ready.
module page_frame_allocator_core #(
    parameter int PAGE_COUNT = 16,
    parameter int PAGE_BYTES = 64,
    parameter int SLOT_COUNT = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_func,
    input  logic [pfa_pkg::OWNER_W-1:0]   i_owner_id,
    input  logic [pfa_pkg::BYTES_W-1:0]   i_request_bytes,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [pfa_pkg::STATUS_W-1:0]  o_status,
    output logic [pfa_pkg::ADDR_W-1:0]    o_page_address,
    output logic [pfa_pkg::COUNT_W-1:0]   o_page_count
);

    pfa_pkg::t_cmd cmd;
    pfa_pkg::t_sts sts;

    pfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    pfa_dp #(
        .PAGE_COUNT (PAGE_COUNT),
        .PAGE_BYTES (PAGE_BYTES),
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_func          (i_func),
        .i_owner_id      (i_owner_id),
        .i_request_bytes (i_request_bytes),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_status        (o_status),
        .o_page_address  (o_page_address),
        .o_page_count    (o_page_count)
    );

endmodule

/* hw/rtl/pfa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/pfa_dp.sv */
// Datapath: page and slot tables, scan index, capacity sum and output register.
module pfa_dp #(
    parameter int PAGE_COUNT = 16,
    parameter int PAGE_BYTES = 64,
    parameter int SLOT_COUNT = 10
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_func,
    input  logic [pfa_pkg::OWNER_W-1:0]    i_owner_id,
    input  logic [pfa_pkg::BYTES_W-1:0]    i_request_bytes,
    input  pfa_pkg::t_cmd                  i_cmd,
    output pfa_pkg::t_sts                  o_sts,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [pfa_pkg::STATUS_W-1:0]   o_status,
    output logic [pfa_pkg::ADDR_W-1:0]     o_page_address,
    output logic [pfa_pkg::COUNT_W-1:0]    o_page_count
);

    localparam int PW   = $clog2(PAGE_COUNT);
    localparam int SW   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int MAXN = (PAGE_COUNT > SLOT_COUNT) ? PAGE_COUNT : SLOT_COUNT;
    localparam int IW   = $clog2(MAXN + 1);
    localparam int CW   = $clog2(PAGE_COUNT + 1);
    localparam int ACCW = $clog2(PAGE_COUNT * PAGE_BYTES + 1);
    localparam int CMPW = (ACCW > pfa_pkg::BYTES_W) ? ACCW : pfa_pkg::BYTES_W;

    // Request word
    logic                         r_func;
    logic [pfa_pkg::OWNER_W-1:0]  r_owner;
    logic [pfa_pkg::BYTES_W-1:0]  r_bytes;

    // Scan state
    logic [IW-1:0]   r_idx;
    logic [ACCW-1:0] r_acc;
    logic [CW-1:0]   r_cnt;
    logic [PW-1:0]   r_last;
    logic [SW-1:0]   r_slot;

    // Tables kept in flops
    logic [PAGE_COUNT-1:0] r_page_used;
    logic [SLOT_COUNT-1:0] r_slot_active;

    // Output register
    logic                          r_out_valid;
    logic [pfa_pkg::STATUS_W-1:0]  r_status;
    logic [pfa_pkg::ADDR_W-1:0]    r_addr;
    logic [pfa_pkg::COUNT_W-1:0]   r_count;

    logic [IW-1:0]                idx_m1;
    logic [PW-1:0]                pg_i;
    logic [PW-1:0]                pg_e;
    logic [SW-1:0]                sl_i;
    logic [SW-1:0]                sl_e;
    logic                         need_more;
    logic                         grant_hit;
    logic                         pg_rel_hit;
    logic                         sl_rel_hit;
    logic                         out_free;
    logic [pfa_pkg::OWNER_W-1:0]  pg_rdata;
    logic [pfa_pkg::OWNER_W-1:0]  sl_rdata;
    logic [31:0]                  addr_prod;
    logic [31:0]                  cnt_wide;

    // Index decode: current entry and the one whose RAM data is back
    assign idx_m1 = r_idx - IW'(1);
    assign pg_i   = r_idx[PW-1:0];
    assign pg_e   = idx_m1[PW-1:0];
    assign sl_i   = r_idx[SW-1:0];
    assign sl_e   = idx_m1[SW-1:0];

    assign need_more  = CMPW'(r_acc) < CMPW'(r_bytes);
    assign grant_hit  = (i_cmd.step == pfa_pkg::STEP_GRANT) && !r_page_used[pg_i] && need_more;
    assign pg_rel_hit = (i_cmd.step == pfa_pkg::STEP_FPAGE) && (r_idx != '0)
                        && r_page_used[pg_e] && (pg_rdata == r_owner);
    assign sl_rel_hit = (i_cmd.step == pfa_pkg::STEP_FSLOT) && (r_idx != '0)
                        && r_slot_active[sl_e] && (sl_rdata == r_owner);
    assign out_free   = !r_out_valid || i_out_ready;

    // Owner tables
    pfa_ram #(
        .WIDTH (pfa_pkg::OWNER_W),
        .DEPTH (PAGE_COUNT)
    ) u_page_owner (
        .i_clk   (i_clk),
        .i_we    (grant_hit),
        .i_waddr (pg_i),
        .i_wdata (r_owner),
        .i_raddr (pg_i),
        .o_rdata (pg_rdata)
    );

    pfa_ram #(
        .WIDTH (pfa_pkg::OWNER_W),
        .DEPTH (SLOT_COUNT)
    ) u_slot_owner (
        .i_clk   (i_clk),
        .i_we    (i_cmd.claim),
        .i_waddr (r_slot),
        .i_wdata (r_owner),
        .i_raddr (sl_i),
        .o_rdata (sl_rdata)
    );

    // Status back to the controller
    always_comb begin
        o_sts.slot_free = !r_slot_active[sl_i];
        o_sts.slot_last = r_idx == IW'(SLOT_COUNT - 1);
        o_sts.page_last = r_idx == IW'(PAGE_COUNT - 1);
        o_sts.fits      = (r_bytes != '0) && !need_more;
        o_sts.need_more = need_more;
        o_sts.page_end  = r_idx == IW'(PAGE_COUNT);
        o_sts.slot_end  = r_idx == IW'(SLOT_COUNT);
        o_sts.any_rel   = r_cnt != '0;
        o_sts.out_free  = out_free;
    end

    // Result formatting
    assign addr_prod = 32'(r_last) * 32'(PAGE_BYTES);
    assign cnt_wide  = 32'(r_cnt);

    // Table bits and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_used   <= '0;
            r_slot_active <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (grant_hit) begin
                r_page_used[pg_i] <= 1'b1;
            end
            if (pg_rel_hit) begin
                r_page_used[pg_e] <= 1'b0;
            end
            if (i_cmd.claim) begin
                r_slot_active[r_slot] <= 1'b1;
            end
            if (sl_rel_hit) begin
                r_slot_active[sl_e] <= 1'b0;
            end
            if (i_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request word, scan registers and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_func;
            r_owner <= i_owner_id;
            r_bytes <= i_request_bytes;
            r_cnt   <= '0;
        end else if (grant_hit || pg_rel_hit) begin
            r_cnt <= r_cnt + CW'(1);
        end

        if (i_cmd.load || i_cmd.clr) begin
            r_idx <= '0;
            r_acc <= '0;
        end else begin
            if (i_cmd.step != pfa_pkg::STEP_NONE) begin
                r_idx <= r_idx + IW'(1);
            end
            if (((i_cmd.step == pfa_pkg::STEP_COUNT) && !r_page_used[pg_i]) || grant_hit) begin
                r_acc <= r_acc + ACCW'(PAGE_BYTES);
            end
        end

        if (grant_hit) begin
            r_last <= pg_i;
        end
        if ((i_cmd.step == pfa_pkg::STEP_SLOT) && !r_slot_active[sl_i]) begin
            r_slot <= sl_i;
        end

        if (i_cmd.res_load) begin
            r_status <= i_cmd.res_code;
            r_count  <= cnt_wide[pfa_pkg::COUNT_W-1:0];
            if ((i_cmd.res_code == pfa_pkg::ST_OK) && (r_func == pfa_pkg::FUNC_ALLOC)) begin
                r_addr <= addr_prod[pfa_pkg::ADDR_W-1:0];
            end else begin
                r_addr <= '0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_page_address = r_addr;
    assign o_page_count   = r_count;

    // Checks
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.res_load |-> (32'(r_cnt) <= PAGE_COUNT))
        else $error("page count beyond table size");

    a_claim_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.claim |=> r_slot_active[$past(r_slot)])
        else $error("claimed slot not active");

    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.res_load |-> out_free)
        else $error("result loaded over an untaken word");

    a_grant_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.claim |-> (r_cnt != '0) && (r_bytes != '0))
        else $error("slot claimed without granted pages");

endmodule

/* hw/rtl/pfa_ctrl.sv */
// Controller: sequences slot and page scans for allocate and free requests.
module pfa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_func,
    output logic          o_in_ready,
    output pfa_pkg::t_cmd o_cmd,
    input  pfa_pkg::t_sts i_sts
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SLOT  = 3'd1;
    localparam logic [2:0] S_COUNT = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_GRANT = 3'd4;
    localparam logic [2:0] S_FPAGE = 3'd5;
    localparam logic [2:0] S_FSLOT = 3'd6;
    localparam logic [2:0] S_RESP  = 3'd7;

    logic [2:0]                   r_state;
    logic [2:0]                   n_state;
    logic [pfa_pkg::STATUS_W-1:0] r_code;
    logic [pfa_pkg::STATUS_W-1:0] n_code;

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state        = r_state;
        n_code         = r_code;
        o_cmd.load     = 1'b0;
        o_cmd.clr      = 1'b0;
        o_cmd.step     = pfa_pkg::STEP_NONE;
        o_cmd.claim    = 1'b0;
        o_cmd.res_load = 1'b0;
        o_cmd.res_code = r_code;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_func == pfa_pkg::FUNC_FREE) ? S_FPAGE : S_SLOT;
                end
            end
            S_SLOT: begin
                o_cmd.step = pfa_pkg::STEP_SLOT;
                if (i_sts.slot_free) begin
                    o_cmd.clr = 1'b1;
                    n_state   = S_COUNT;
                end else if (i_sts.slot_last) begin
                    n_code  = pfa_pkg::ST_TABLE_FULL;
                    n_state = S_RESP;
                end
            end
            S_COUNT: begin
                o_cmd.step = pfa_pkg::STEP_COUNT;
                if (i_sts.page_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.clr = 1'b1;
                if (i_sts.fits) begin
                    n_state = S_GRANT;
                end else begin
                    n_code  = pfa_pkg::ST_NO_PAGES;
                    n_state = S_RESP;
                end
            end
            S_GRANT: begin
                if (i_sts.need_more) begin
                    o_cmd.step = pfa_pkg::STEP_GRANT;
                end else begin
                    o_cmd.claim = 1'b1;
                    n_code      = pfa_pkg::ST_OK;
                    n_state     = S_RESP;
                end
            end
            S_FPAGE: begin
                o_cmd.step = pfa_pkg::STEP_FPAGE;
                if (i_sts.page_end) begin
                    o_cmd.clr = 1'b1;
                    n_state   = S_FSLOT;
                end
            end
            S_FSLOT: begin
                o_cmd.step = pfa_pkg::STEP_FSLOT;
                if (i_sts.slot_end) begin
                    n_code  = i_sts.any_rel ? pfa_pkg::ST_OK : pfa_pkg::ST_NOT_FOUND;
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_code  <= pfa_pkg::ST_OK;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    // Checks
    a_grant_from_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GRANT) |-> ($past(r_state) == S_CHECK) || ($past(r_state) == S_GRANT))
        else $error("grant entered without capacity check");

    a_load_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_SLOT) || (r_state == S_FPAGE))
        else $error("accepted word did not start a scan");

    a_resp_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.res_load |=> (r_state == S_IDLE))
        else $error("result loaded but controller not idle");

endmodule
